[sv/printf_integer_field_formatter_core_defines.svh]
// Assertion macros for the printf field formatter.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef PRINTF_INTEGER_FIELD_FORMATTER_CORE_DEFINES_SVH
`define PRINTF_INTEGER_FIELD_FORMATTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Property p must hold at every rising clock edge outside reset.
`define PIF_ASSERT(lbl, c, r, p) lbl: assert property (@(posedge c) disable iff (!r) p) \
	else $error("assertion failed");
// Condition p must never be true outside reset.
`define PIF_NEVER(lbl, c, r, p) lbl: assert property (@(posedge c) disable iff (!r) !(p)) \
	else $error("forbidden condition");
`else
`define PIF_ASSERT(lbl, c, r, p)
`define PIF_NEVER(lbl, c, r, p)
`endif
`endif

[sv/pifmt_pkg.sv]
// Shared types, codes and helpers of the printf field formatter.
// No dependencies; used by the core, front, queue and back RTL files.
`default_nettype none
package pifmt_pkg;
	localparam int CNT_W = 7;
	localparam int NDIG  = 11;
	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		OP_CHAR = 3'd0, OP_SDEC = 3'd1, OP_UDEC = 3'd2, OP_HEXL = 3'd3,
		OP_HEXU = 3'd4, OP_OCT  = 3'd5, OP_PTR  = 3'd6, OP_PCT  = 3'd7
	} op_t;

	typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} fstate_t;

	typedef enum logic [2:0] {
		P_LEAD, P_SIGN, P_ZERO, P_LIT, P_BODY, P_TRAIL
	} phase_t;

	// One classified field, ready to be emitted.
	typedef struct packed {
		logic [CNT_W-1:0]        lead;
		logic [CNT_W-1:0]        zeros;
		logic [CNT_W-1:0]        trail;
		logic                    has_sign;
		logic [7:0]              sign_char;
		logic                    lit0x;
		logic                    raw;
		logic [7:0]              raw_byte;
		logic                    upper;
		logic [3:0]              nd;
		logic [NDIG-1:0][3:0]    dig;
	} desc_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else if (upper) begin
			c = 8'h37 + {4'd0, nib};
		end else begin
			c = 8'h57 + {4'd0, nib};
		end
		return c;
	endfunction
endpackage
`default_nettype wire

[sv/pifmt_if.sv]
// Valid/ready channel interfaces for conversion items and output characters.
// Uses pifmt_pkg for nothing but follows it in compile order.
`default_nettype none
interface pifmt_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [31:0] value;
	logic       flag_minus;
	logic       flag_zero;
	logic       flag_plus;
	logic       flag_space;
	logic [5:0] field_width;
	logic       has_precision;
	logic [5:0] precision_digits;
	modport source(output valid, op, value, flag_minus, flag_zero, flag_plus, flag_space,
		field_width, has_precision, precision_digits, input ready);
	modport sink(input valid, op, value, flag_minus, flag_zero, flag_plus, flag_space,
		field_width, has_precision, precision_digits, output ready);
endinterface

interface pifmt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;
	modport source(output valid, character, last, input ready);
	modport sink(input valid, character, last, output ready);
endinterface
`default_nettype wire

[sv/printf_integer_field_formatter_core.sv]
// The front converts the value digit by digit (up to 11 digits for octal) and then
// enqueues the descriptor; it takes no new item until the last one is enqueued. The
// back end steps over empty leading phases before the first character, and then sends
// one character per cycle while fmt_out.ready drains the output register, up to 63 per
// item, stepping over empty phases ahead of the last. Reset (arst_n low) empties the
// queue and output.
`default_nettype none
module printf_integer_field_formatter_core #(
	parameter int MAX_WIDTH = 63
) (
	input wire          clk,
	input wire          arst_n,
	pifmt_in_if.sink    fmt_in,
	pifmt_out_if.source fmt_out
);
	import pifmt_pkg::*;

	desc_t f_desc, q_desc;
	logic  push, full, head_valid, pop;

	// Classification and digit conversion.
	pifmt_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .fmt_in(fmt_in),
		.desc(f_desc), .push(push), .full(full)
	);

	// Decoupling queue.
	pifmt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_data(f_desc), .push(push), .full(full),
		.rd_data(q_desc), .head_valid(head_valid), .pop(pop)
	);

	// Character emission.
	pifmt_back u_back (
		.clk(clk), .arst_n(arst_n), .desc(q_desc), .head_valid(head_valid),
		.pop(pop), .fmt_out(fmt_out)
	);
endmodule
`default_nettype wire

[sv/pifmt_front.sv]
// Front end: accepts a conversion item, converts the value to digits one per
// cycle and builds a field descriptor. Depends on pifmt_pkg and pifmt_in_if.
`default_nettype none
module pifmt_front #(
	parameter int MAX_WIDTH = 63
) (
	input  wire              clk,
	input  wire              arst_n,
	pifmt_in_if.sink         fmt_in,
	output pifmt_pkg::desc_t desc,
	output logic             push,
	input  wire              full
);
	import pifmt_pkg::*;

	localparam logic [7:0] MAXW = 8'(MAX_WIDTH);

	fstate_t state_q, state_d;
	op_t        op_q;
	logic [31:0] v_q;
	logic       left_q, zpad_q, plus_q, space_q, hasp_q, neg_q;
	logic [5:0] w_q, prec_q;
	logic [NDIG-1:0][3:0] dig_q;
	logic [3:0] nd_q;

	logic [63:0] prod;
	logic [28:0] q10;
	logic [31:0] rem;
	logic [31:0] vnext;
	logic        conv_done;
	logic        acc;

	// One digit per cycle: divide by ten through a reciprocal, or shift.
	always_comb begin
		prod = 64'(v_q) * 64'(32'hCCCCCCCD);
		q10  = prod[63:35];
		rem  = 32'd0;
		vnext = 32'd0;
		case (op_q)
			OP_SDEC, OP_UDEC: begin
				rem   = v_q - {q10, 3'b000} - {2'b00, q10, 1'b0};
				vnext = {3'b000, q10};
			end
			OP_OCT: begin
				rem   = {29'd0, v_q[2:0]};
				vnext = {3'b000, v_q[31:3]};
			end
			default: begin
				rem   = {28'd0, v_q[3:0]};
				vnext = {4'd0, v_q[31:4]};
			end
		endcase
		if (op_q == OP_PTR) begin
			conv_done = (nd_q == 4'd7);
		end else begin
			conv_done = (vnext == 32'd0);
		end
	end

	// Next state and handshake.
	always_comb begin
		state_d = state_q;
		fmt_in.ready = (state_q == F_IDLE);
		acc = fmt_in.valid && fmt_in.ready;
		push = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (acc) begin
					if (op_t'(fmt_in.op) == OP_CHAR || op_t'(fmt_in.op) == OP_PCT) begin
						state_d = F_PUSH;
					end else begin
						state_d = F_CONV;
					end
				end
			end
			F_CONV: begin
				if (conv_done) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!full) begin
					push = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item capture and digit registers.
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q    <= op_t'(fmt_in.op);
			left_q  <= fmt_in.flag_minus;
			zpad_q  <= fmt_in.flag_zero;
			plus_q  <= fmt_in.flag_plus;
			space_q <= fmt_in.flag_space;
			hasp_q  <= fmt_in.has_precision;
			prec_q  <= fmt_in.precision_digits;
			if ({2'b00, fmt_in.field_width} > MAXW) begin
				w_q <= MAXW[5:0];
			end else begin
				w_q <= fmt_in.field_width;
			end
			neg_q <= (op_t'(fmt_in.op) == OP_SDEC) && fmt_in.value[31];
			if (op_t'(fmt_in.op) == OP_SDEC && fmt_in.value[31]) begin
				v_q <= 32'd0 - fmt_in.value;
			end else begin
				v_q <= fmt_in.value;
			end
			nd_q <= 4'd0;
		end else if (state_q == F_CONV) begin
			dig_q[nd_q] <= rem[3:0];
			nd_q <= nd_q + 4'd1;
			v_q  <= vnext;
		end
	end

	// Descriptor built from the captured item and its digits.
	logic [CNT_W-1:0] want, ext, body, total, pad, w7;
	logic             prec_ok, sgn;
	always_comb begin
		prec_ok = hasp_q && (op_q == OP_SDEC || op_q == OP_UDEC ||
			op_q == OP_HEXL || op_q == OP_HEXU);
		if (op_q == OP_SDEC) begin
			want = ({1'b0, prec_q} < 7'd22) ? {1'b0, prec_q} : 7'd22;
		end else begin
			want = ({1'b0, prec_q} < 7'd23) ? {1'b0, prec_q} : 7'd23;
		end
		ext = (prec_ok && want > {3'b000, nd_q}) ? want - {3'b000, nd_q} : 7'd0;
		sgn = (op_q == OP_SDEC) && (neg_q || plus_q || space_q);
		if (op_q == OP_CHAR || op_q == OP_PCT) begin
			body = 7'd1;
		end else if (op_q == OP_PTR) begin
			body = {3'b000, nd_q} + 7'd2;
		end else begin
			body = {3'b000, nd_q};
		end
		total = body + ext + {6'd0, sgn};
		w7 = {1'b0, w_q};
		pad = (op_q != OP_PCT && w7 > total) ? w7 - total : 7'd0;

		desc.lead      = (!left_q && !zpad_q) ? pad : 7'd0;
		desc.zeros     = ext + ((!left_q && zpad_q) ? pad : 7'd0);
		desc.trail     = left_q ? pad : 7'd0;
		desc.has_sign  = sgn;
		desc.sign_char = neg_q ? 8'h2D : (plus_q ? 8'h2B : 8'h20);
		desc.lit0x     = (op_q == OP_PTR);
		desc.raw       = (op_q == OP_CHAR || op_q == OP_PCT);
		desc.raw_byte  = (op_q == OP_PCT) ? 8'h25 : v_q[7:0];
		desc.upper     = (op_q == OP_HEXU);
		desc.nd        = nd_q;
		desc.dig       = dig_q;
	end
endmodule
`default_nettype wire

[sv/pifmt_queue.sv]
// Two-entry descriptor queue between the front and back ends.
// Depends on pifmt_pkg.
`default_nettype none
`include "printf_integer_field_formatter_core_defines.svh"
module pifmt_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  pifmt_pkg::desc_t wr_data,
	input  wire              push,
	output logic             full,
	output pifmt_pkg::desc_t rd_data,
	output logic             head_valid,
	input  wire              pop
);
	import pifmt_pkg::*;

	desc_t      mem_q [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'(QDEPTH));
	assign head_valid = (cnt_q != 2'd0);
	assign rd_data    = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	`PIF_NEVER(a_no_overflow, clk, arst_n, push && full)
	`PIF_NEVER(a_no_underflow, clk, arst_n, pop && !head_valid)
	`PIF_ASSERT(a_ptrs_track, clk, arst_n, (cnt_q == 2'd1) |-> (wp_q != rp_q))
endmodule
`default_nettype wire

[sv/pifmt_back.sv]
// Back end: walks a field descriptor phase by phase and emits one character per
// cycle unless stalled into an output register. Depends on pifmt_pkg and pifmt_out_if.
`default_nettype none
`include "printf_integer_field_formatter_core_defines.svh"
module pifmt_back (
	input  wire              clk,
	input  wire              arst_n,
	input  pifmt_pkg::desc_t desc,
	input  wire              head_valid,
	output logic             pop,
	pifmt_out_if.source      fmt_out
);
	import pifmt_pkg::*;

	phase_t           phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ov_q, last_q;
	logic [7:0]       ch_q;

	logic [CNT_W-1:0] len_a [6];
	logic [CNT_W-1:0] cur_len;
	logic             later_empty, emit, last_c, slot;
	logic [7:0]       ch_c;
	logic [3:0]       didx;

	// Phase lengths and the current character.
	always_comb begin
		len_a[0] = desc.lead;
		len_a[1] = {6'd0, desc.has_sign};
		len_a[2] = desc.zeros;
		len_a[3] = desc.lit0x ? 7'd2 : 7'd0;
		len_a[4] = desc.raw ? 7'd1 : {3'b000, desc.nd};
		len_a[5] = desc.trail;
		cur_len = len_a[phase_q];
		later_empty = 1'b1;
		for (int k = 0; k < 6; k++) begin
			if (k > int'(phase_q) && len_a[k] != 7'd0) later_empty = 1'b0;
		end
		didx = desc.nd - 4'd1 - cnt_q[3:0];
		case (phase_q)
			P_SIGN:  ch_c = desc.sign_char;
			P_ZERO:  ch_c = 8'h30;
			P_LIT:   ch_c = (cnt_q == 7'd0) ? 8'h30 : 8'h78;
			P_BODY:  ch_c = desc.raw ? desc.raw_byte : hex_char(desc.dig[didx], desc.upper);
			default: ch_c = 8'h20;
		endcase
		slot   = !ov_q || fmt_out.ready;
		emit   = head_valid && slot && (cnt_q < cur_len);
		last_c = (cnt_q + 7'd1 == cur_len) && later_empty;
		pop    = emit && last_c;
	end

	// Phase sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_LEAD;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= P_LEAD;
				cnt_q   <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + 7'd1;
			end else if (head_valid && slot) begin
				phase_q <= phase_t'(3'(phase_q) + 3'd1);
				cnt_q   <= '0;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (fmt_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			ch_q   <= ch_c;
			last_q <= last_c;
		end
	end

	assign fmt_out.valid     = ov_q;
	assign fmt_out.character = ch_q;
	assign fmt_out.last      = last_q;

	`PIF_NEVER(a_pop_needs_head, clk, arst_n, pop && !head_valid)
	`PIF_ASSERT(a_restart, clk, arst_n, pop |=> (phase_q == P_LEAD && cnt_q == 7'd0))
	`PIF_ASSERT(a_last_pops, clk, arst_n, pop |=> (ov_q && last_q))
endmodule
`default_nettype wire
